// ===== sv/assert_macros.svh =====
// Assertion macros shared by the classifier RTL.
// Each macro expects a clock i_clk and an active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define PUR_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PUR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PUR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pur_pkg.sv =====
// Package for the prefetch usefulness classifier.
// Field widths, default sizes, opcode and class codes; no dependencies.
package pur_pkg;

    localparam int ENTRY_COUNT  = 256;
    localparam int CORE_COUNT   = 8;
    localparam int COUNTER_BITS = 16;

    localparam int OPCODE_BITS    = 2;
    localparam int INDEX_BITS     = 8;
    localparam int MASK_BITS      = 8;
    localparam int THRESH_BITS    = 16;
    localparam int CLASS_BITS     = 3;
    localparam int CNT_BITS       = $clog2(MASK_BITS + 1);
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_OWN_MASK  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 1'b1;

    localparam logic [MASK_BITS-1:0]   OWN_MASK_RESET  = 8'd1;
    localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 16'd2;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_CLEAR   = 2'd0,
        OP_USEFUL  = 2'd1,
        OP_HARMFUL = 2'd2,
        OP_QUERY   = 2'd3
    } t_opcode;

    typedef enum logic [CLASS_BITS-1:0] {
        CLS_CROSS_USEFUL   = 3'd0,
        CLS_SINGLE_USEFUL  = 3'd1,
        CLS_SELFISH        = 3'd2,
        CLS_SELFLESS       = 3'd3,
        CLS_USELESS        = 3'd4,
        CLS_SINGLE_HARMFUL = 3'd5,
        CLS_CROSS_HARMFUL  = 3'd6,
        CLS_NONE           = 3'd7
    } t_class;

    typedef struct packed {
        t_class class_code;
        logic   useful_flag;
    } t_result;

endpackage

// ===== sv/prefetch_usefulness_classifier.sv =====
// Top level of the prefetch usefulness classifier.
// Depends on pur_pkg, pur_ram, pur_update, pur_classify and assert_macros.svh.

// One item is in flight at a time and passes three steps from transfer to result:
// the counter table read (registered RAM read data), the saturating update with
// write-back, and classification into the output register. A new item is taken
// only once the previous one has reached the output register; a waiting result
// does not block the next transfer. After reset the table is zeroed by a clearing
// pass over all ENTRY_COUNT entries, during which no item is taken; configuration
// writes are taken at any time. Items whose entry index is at or above ENTRY_COUNT
// leave the table untouched and report class none with the flag low.
module prefetch_usefulness_classifier #(
    parameter int ENTRY_COUNT  = pur_pkg::ENTRY_COUNT,
    parameter int CORE_COUNT   = pur_pkg::CORE_COUNT,
    parameter int COUNTER_BITS = pur_pkg::COUNTER_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [pur_pkg::OPCODE_BITS-1:0]    i_opcode,
    input  logic [pur_pkg::INDEX_BITS-1:0]     i_entry_index,
    input  logic [pur_pkg::MASK_BITS-1:0]      i_requester_mask,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [pur_pkg::CLASS_BITS-1:0]     o_class_code,
    output logic                               o_useful_flag,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pur_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [pur_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

`include "assert_macros.svh"

    localparam int ADDR_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int WORD_W = 4 * COUNTER_BITS;
    localparam int XW     = ADDR_W + pur_pkg::INDEX_BITS;

    // configuration
    logic [pur_pkg::MASK_BITS-1:0]   r_own_mask;
    logic [pur_pkg::THRESH_BITS-1:0] r_threshold;

    // clearing pass
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // stage 1: table read outstanding
    logic                          r_s1_vld;
    pur_pkg::t_opcode              r_s1_op;
    logic [ADDR_W-1:0]             r_s1_addr;
    logic                          r_s1_inrange;
    logic [pur_pkg::MASK_BITS-1:0] r_s1_req;

    // stage 2: updated counters held for classification
    logic              r_s2_vld;
    logic              r_s2_inrange;
    logic [WORD_W-1:0] r_s2_cnt;

    // output register
    logic             r_out_vld;
    pur_pkg::t_result r_out;

    logic              in_acc;
    logic              in_range;
    logic [XW-1:0]     idx_ext;
    logic [ADDR_W-1:0] in_addr;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] upd_word;
    logic              upd_write;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              out_free;
    pur_pkg::t_result  cls_result;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_clr_busy || r_s1_vld || r_s2_vld;
    assign in_acc      = i_in_valid && !o_in_stall;

    assign idx_ext  = {{ADDR_W{1'b0}}, i_entry_index};
    assign in_addr  = idx_ext[ADDR_W-1:0];
    assign in_range = 32'(i_entry_index) < 32'(ENTRY_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mask  <= pur_pkg::OWN_MASK_RESET;
            r_threshold <= pur_pkg::THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pur_pkg::CFG_OWN_MASK:  r_own_mask  <= i_cfg_data[pur_pkg::MASK_BITS-1:0];
                pur_pkg::CFG_THRESHOLD: r_threshold <= i_cfg_data[pur_pkg::THRESH_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(ENTRY_COUNT - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    pur_update #(
        .COUNTER_BITS (COUNTER_BITS),
        .CORE_COUNT   (CORE_COUNT)
    ) u_update (
        .i_op       (r_s1_op),
        .i_req      (r_s1_req),
        .i_own_mask (r_own_mask),
        .i_word     (rd_word),
        .o_word     (upd_word),
        .o_write    (upd_write)
    );

    // Clearing pass and item write-back never overlap: no transfer during the pass.
    assign ram_we    = r_clr_busy || (r_s1_vld && r_s1_inrange && upd_write);
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clr_busy ? '0 : upd_word;

    pur_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRY_COUNT)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_acc && in_range),
        .i_raddr (in_addr),
        .o_rdata (rd_word)
    );

    pur_classify #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_classify (
        .i_word      (r_s2_cnt),
        .i_threshold (r_threshold),
        .o_result    (cls_result)
    );

    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_acc;
            if (r_s1_vld) begin
                r_s2_vld <= 1'b1;
            end else if (r_s2_vld && out_free) begin
                r_s2_vld <= 1'b0;
            end
            if (r_s2_vld && out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op      <= pur_pkg::t_opcode'(i_opcode);
            r_s1_addr    <= in_addr;
            r_s1_inrange <= in_range;
            r_s1_req     <= i_requester_mask;
        end
        if (r_s1_vld) begin
            r_s2_cnt     <= upd_word;
            r_s2_inrange <= r_s1_inrange;
        end
        if (r_s2_vld && out_free) begin
            if (r_s2_inrange) begin
                r_out <= cls_result;
            end else begin
                r_out.class_code  <= pur_pkg::CLS_NONE;
                r_out.useful_flag <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_class_code  = r_out.class_code;
    assign o_useful_flag = r_out.useful_flag;

    `PUR_ASSERT(a_one_in_flight, !(r_s1_vld && r_s2_vld), "two items in flight")
    `PUR_ASSERT_NXT(a_s1_to_s2, r_s1_vld, r_s2_vld && !r_s1_vld, "stage 1 did not advance")
    `PUR_ASSERT_IMP(a_no_item_in_clear, r_clr_busy, !r_s1_vld && !r_s2_vld, "item during clear")
    `PUR_ASSERT_IMP(a_oor_no_write, r_s1_vld && !r_s1_inrange, !ram_we, "out-of-range write")
    `PUR_ASSERT_NXT(a_clear_zero, r_s1_vld && r_s1_inrange && r_s1_op == pur_pkg::OP_CLEAR, r_s2_cnt == '0, "clear left counts")

endmodule

// ===== sv/pur_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; used for the counter table.
module pur_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/pur_update.sv =====
// Counter update for one table entry: popcount split and saturating adds, or a clear to zero.
// Depends on pur_pkg for field widths and opcodes.
module pur_update #(
    parameter int COUNTER_BITS = pur_pkg::COUNTER_BITS,
    parameter int CORE_COUNT   = pur_pkg::CORE_COUNT
) (
    input  pur_pkg::t_opcode                 i_op,
    input  logic [pur_pkg::MASK_BITS-1:0]    i_req,
    input  logic [pur_pkg::MASK_BITS-1:0]    i_own_mask,
    input  logic [4*COUNTER_BITS-1:0]        i_word,
    output logic [4*COUNTER_BITS-1:0]        o_word,
    output logic                             o_write
);

    localparam int CB = COUNTER_BITS;
    localparam int CW = pur_pkg::CNT_BITS;

    logic [pur_pkg::MASK_BITS-1:0] core_valid;
    logic [pur_pkg::MASK_BITS-1:0] req;
    logic [CW-1:0]                 own_n;
    logic [CW-1:0]                 cross_n;
    logic [CB-1:0]                 ou, oh, cu, ch;

    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [CW-1:0] b);
        logic [CB:0] s;
        s = {1'b0, a} + (CB + 1)'(b);
        return s[CB] ? {CB{1'b1}} : s[CB-1:0];
    endfunction

    always_comb begin
        for (int j = 0; j < pur_pkg::MASK_BITS; j++) begin
            core_valid[j] = (j < CORE_COUNT);
        end
    end

    assign req     = i_req & core_valid;
    assign own_n   = CW'($countones(req & i_own_mask));
    assign cross_n = CW'($countones(req & ~i_own_mask));

    assign ou = i_word[CB-1:0];
    assign oh = i_word[2*CB-1:CB];
    assign cu = i_word[3*CB-1:2*CB];
    assign ch = i_word[4*CB-1:3*CB];

    always_comb begin
        o_word  = i_word;
        o_write = 1'b1;
        case (i_op)
            pur_pkg::OP_CLEAR:   o_word = '0;
            pur_pkg::OP_USEFUL:  o_word = {ch, sat_add(cu, cross_n), oh, sat_add(ou, own_n)};
            pur_pkg::OP_HARMFUL: o_word = {sat_add(ch, cross_n), cu, sat_add(oh, own_n), ou};
            default:             o_write = 1'b0;
        endcase
    end

endmodule

// ===== sv/pur_classify.sv =====
// Class and usefulness flag from the four counters of one entry.
// Depends on pur_pkg for the class codes and the result struct.
module pur_classify #(
    parameter int COUNTER_BITS = pur_pkg::COUNTER_BITS
) (
    input  logic [4*COUNTER_BITS-1:0]       i_word,
    input  logic [pur_pkg::THRESH_BITS-1:0] i_threshold,
    output pur_pkg::t_result                o_result
);

    localparam int CB = COUNTER_BITS;
    localparam int DW = ((CB > pur_pkg::THRESH_BITS) ? CB : pur_pkg::THRESH_BITS) + 2;

    logic signed [DW-1:0] ou, oh, cu, ch, thr;
    logic signed [DW-1:0] d_own, d_cross;

    assign ou  = DW'(i_word[CB-1:0]);
    assign oh  = DW'(i_word[2*CB-1:CB]);
    assign cu  = DW'(i_word[3*CB-1:2*CB]);
    assign ch  = DW'(i_word[4*CB-1:3*CB]);
    assign thr = DW'(i_threshold);

    assign d_own   = ou - oh;
    assign d_cross = cu - ch;

    // First matching rule wins; zero on one side with harm on the other is no class.
    always_comb begin
        if (d_own >= 0 && d_cross > 0 && d_own < d_cross) begin
            o_result.class_code = pur_pkg::CLS_CROSS_USEFUL;
        end else if (d_own > 0 && d_cross >= 0) begin
            o_result.class_code = pur_pkg::CLS_SINGLE_USEFUL;
        end else if (d_own > 0 && d_cross < 0) begin
            o_result.class_code = pur_pkg::CLS_SELFISH;
        end else if (d_own < 0 && d_cross > 0) begin
            o_result.class_code = pur_pkg::CLS_SELFLESS;
        end else if (d_own == 0 && d_cross == 0) begin
            o_result.class_code = pur_pkg::CLS_USELESS;
        end else if (d_own < 0 && d_cross < 0 && d_own < d_cross) begin
            o_result.class_code = pur_pkg::CLS_SINGLE_HARMFUL;
        end else if (d_own < 0 && d_cross < 0) begin
            o_result.class_code = pur_pkg::CLS_CROSS_HARMFUL;
        end else begin
            o_result.class_code = pur_pkg::CLS_NONE;
        end
        o_result.useful_flag = (d_own > thr && d_cross >= 0) || (d_cross > thr && d_own >= 0);
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench for prefetch_usefulness_classifier: directed, configuration, tie,
// back-pressure and random tests, scored against a behavioral copy of the counter table.
// Depends on pur_pkg and the classifier RTL.
module tb_top;
    import pur_pkg::*;

    localparam int LONG_HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES    = 6;
    localparam int TIE_EVENTS       = 32;
    localparam int RANDOM_PHASES    = 6;
    localparam int PHASE_ITEMS      = 130;
    localparam logic [INDEX_BITS-1:0] TIE_ENTRY = 8'd200;
    localparam int CNT_MAX          = (1 << COUNTER_BITS) - 1;
    localparam logic [MASK_BITS-1:0] CORE_BITS =
        (CORE_COUNT >= MASK_BITS) ? '1 : MASK_BITS'((1 << CORE_COUNT) - 1);

    logic                      i_clk            = 1'b0;
    logic                      i_rst_n          = 1'b0;
    logic                      i_in_valid       = 1'b0;
    logic                      o_in_stall;
    logic [OPCODE_BITS-1:0]    i_opcode         = '0;
    logic [INDEX_BITS-1:0]     i_entry_index    = '0;
    logic [MASK_BITS-1:0]      i_requester_mask = '0;
    logic                      o_out_valid;
    logic                      i_out_stall      = 1'b0;
    logic [CLASS_BITS-1:0]     o_class_code;
    logic                      o_useful_flag;
    logic                      i_cfg_valid      = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index      = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data       = '0;

    // Counter table and registers as the block should hold them
    int                   own_use    [ENTRY_COUNT];
    int                   own_harm   [ENTRY_COUNT];
    int                   cross_use  [ENTRY_COUNT];
    int                   cross_harm [ENTRY_COUNT];
    logic [MASK_BITS-1:0]   own_mask_reg  = OWN_MASK_RESET;
    logic [THRESH_BITS-1:0] threshold_reg = THRESHOLD_RESET;

    t_result expected_results[$];
    int      error_count   = 0;
    bit      input_bursts  = 1'b0;
    bit      output_bursts = 1'b0;
    bit      long_hold_req = 1'b0;

    prefetch_usefulness_classifier u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_opcode         (i_opcode),
        .i_entry_index    (i_entry_index),
        .i_requester_mask (i_requester_mask),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_class_code     (o_class_code),
        .o_useful_flag    (o_useful_flag),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int sat_add(int a, int b);
        return (a + b > CNT_MAX) ? CNT_MAX : a + b;
    endfunction

    // First matching rule wins
    function automatic t_class class_of(int ou, int oh, int cu, int ch);
        if (ou >= oh && cu > ch && (ou - oh) < (cu - ch)) return CLS_CROSS_USEFUL;
        if (ou > oh && cu >= ch && (ou - oh) >= (cu - ch)) return CLS_SINGLE_USEFUL;
        if (ou > oh && cu < ch) return CLS_SELFISH;
        if (ou < oh && cu > ch) return CLS_SELFLESS;
        if (ou == oh && cu == ch) return CLS_USELESS;
        if (ou < oh && cu < ch && (oh - ou) > (ch - cu)) return CLS_SINGLE_HARMFUL;
        if (ou < oh && cu < ch && (oh - ou) <= (ch - cu)) return CLS_CROSS_HARMFUL;
        return CLS_NONE;
    endfunction

    function automatic t_result update_entry(t_opcode op, logic [INDEX_BITS-1:0] idx,
                                             logic [MASK_BITS-1:0] req);
        logic [MASK_BITS-1:0] live;
        int own_n, cross_n, ou, oh, cu, ch, thr;
        t_result res;
        res.class_code  = CLS_NONE;
        res.useful_flag = 1'b0;
        if (int'(idx) >= ENTRY_COUNT) return res;
        live    = req & CORE_BITS;
        own_n   = $countones(live & own_mask_reg);
        cross_n = $countones(live & ~own_mask_reg);
        case (op)
            OP_CLEAR: begin
                own_use[idx]    = 0;
                own_harm[idx]   = 0;
                cross_use[idx]  = 0;
                cross_harm[idx] = 0;
            end
            OP_USEFUL: begin
                own_use[idx]   = sat_add(own_use[idx], own_n);
                cross_use[idx] = sat_add(cross_use[idx], cross_n);
            end
            OP_HARMFUL: begin
                own_harm[idx]   = sat_add(own_harm[idx], own_n);
                cross_harm[idx] = sat_add(cross_harm[idx], cross_n);
            end
            default: ;
        endcase
        ou  = own_use[idx];
        oh  = own_harm[idx];
        cu  = cross_use[idx];
        ch  = cross_harm[idx];
        thr = int'(threshold_reg);
        res.useful_flag = ((ou - oh) > thr && cu >= ch) || ((cu - ch) > thr && ou >= oh);
        res.class_code  = class_of(ou, oh, cu, ch);
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(t_opcode op, logic [INDEX_BITS-1:0] idx,
                             logic [MASK_BITS-1:0] req);
        if (input_bursts && $urandom_range(0, 3) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid       = 1'b1;
        i_opcode         = op;
        i_entry_index    = idx;
        i_requester_mask = req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.insert(expected_results.size(), update_entry(op, idx, req));
        @(negedge i_clk);
    endtask

    task automatic send_random_item(logic [INDEX_BITS-1:0] base);
        int pick;
        t_opcode op;
        logic [INDEX_BITS-1:0] idx;
        logic [MASK_BITS-1:0] req;
        pick = $urandom_range(0, 99);
        if (pick < 38)      op = OP_USEFUL;
        else if (pick < 76) op = OP_HARMFUL;
        else if (pick < 96) op = OP_QUERY;
        else                op = OP_CLEAR;
        // Mostly a small pool of entries so counters build up
        if ($urandom_range(0, 9) == 0) idx = INDEX_BITS'($urandom());
        else                           idx = base + INDEX_BITS'($urandom_range(0, 7));
        case ($urandom_range(0, 2))
            0:       req = MASK_BITS'($urandom());
            1:       req = MASK_BITS'(1 << $urandom_range(0, MASK_BITS - 1));
            default: req = MASK_BITS'($urandom()) & MASK_BITS'($urandom());
        endcase
        send_item(op, idx, req);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_OWN_MASK) own_mask_reg  = data[MASK_BITS-1:0];
        else                     threshold_reg = data[THRESH_BITS-1:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_config(logic [MASK_BITS-1:0] own_mask, logic [THRESH_BITS-1:0] thr);
        wait_idle();
        write_reg(CFG_OWN_MASK, CFG_DATA_BITS'(own_mask));
        write_reg(CFG_THRESHOLD, CFG_DATA_BITS'(thr));
    endtask

    // Reset settings: every class, every opcode, threshold boundary
    task automatic test_directed();
        send_item(OP_QUERY,   8'd0,   8'h00);
        send_item(OP_QUERY,   8'd255, 8'hFF);
        send_item(OP_USEFUL,  8'd0,   8'h01);
        send_item(OP_USEFUL,  8'd0,   8'hFF);
        send_item(OP_HARMFUL, 8'd0,   8'hFE);
        send_item(OP_USEFUL,  8'd0,   8'h01);
        send_item(OP_HARMFUL, 8'd1,   8'h01);
        send_item(OP_HARMFUL, 8'd1,   8'h02);
        send_item(OP_HARMFUL, 8'd1,   8'h01);
        send_item(OP_USEFUL,  8'd2,   8'h01);
        send_item(OP_HARMFUL, 8'd2,   8'h02);
        send_item(OP_HARMFUL, 8'd3,   8'h01);
        send_item(OP_USEFUL,  8'd3,   8'h02);
        send_item(OP_CLEAR,   8'd0,   8'hFF);
        send_item(OP_QUERY,   8'd0,   8'h00);
        send_item(OP_USEFUL,  8'd255, 8'h00);
        send_item(OP_USEFUL,  8'd4,   8'hFF);
        send_item(OP_HARMFUL, 8'd4,   8'hFF);
        send_item(OP_USEFUL,  8'd4,   8'h80);
        wait_idle();
    endtask

    task automatic test_config_extremes();
        set_config(8'hFF, 16'd0);
        send_item(OP_USEFUL,  8'd10, 8'h01);
        send_item(OP_HARMFUL, 8'd10, 8'h01);
        send_item(OP_USEFUL,  8'd10, 8'h80);
        set_config(8'h00, 16'hFFFF);
        send_item(OP_USEFUL,  8'd11, 8'hFF);
        send_item(OP_QUERY,   8'd11, 8'h00);
        send_item(OP_HARMFUL, 8'd11, 8'h7F);
        set_config(8'hA5, 16'd3);
        send_item(OP_USEFUL,  8'd12, 8'hFF);
        send_item(OP_HARMFUL, 8'd12, 8'h5A);
        send_item(OP_USEFUL,  8'd12, 8'h5A);
        wait_idle();
    endtask

    // Build up the use counters of one entry, then the harm counters
    // to the same count: the entry must come back to a tie
    task automatic test_tie();
        input_bursts  = 1'b0;
        output_bursts = 1'b0;
        set_config(8'h0F, 16'd0);
        send_item(OP_CLEAR, TIE_ENTRY, 8'h00);
        repeat (TIE_EVENTS) send_item(OP_USEFUL, TIE_ENTRY, 8'hFF);
        send_item(OP_QUERY, TIE_ENTRY, 8'h00);
        repeat (TIE_EVENTS) send_item(OP_HARMFUL, TIE_ENTRY, 8'hFF);
        send_item(OP_QUERY, TIE_ENTRY, 8'h00);
        wait_idle();
    endtask

    // Hold the result side long enough for the block to stall its input
    task automatic test_backpressure();
        set_config(8'h33, 16'd4);
        input_bursts  = 1'b0;
        output_bursts = 1'b0;
        long_hold_req = 1'b1;
        repeat (24) send_random_item(8'd40);
        wait_idle();
    endtask

    task automatic test_random();
        logic [INDEX_BITS-1:0] base;
        logic [THRESH_BITS-1:0] thr;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if ($urandom_range(0, 3) == 0) thr = THRESH_BITS'($urandom());
            else                           thr = THRESH_BITS'($urandom_range(0, 12));
            set_config(MASK_BITS'($urandom()), thr);
            // One quiet phase in the middle and a quiet tail
            input_bursts  = (phase != 2) && (phase != RANDOM_PHASES - 1);
            output_bursts = input_bursts;
            base = INDEX_BITS'($urandom_range(0, ENTRY_COUNT - 8));
            repeat (PHASE_ITEMS) send_random_item(base);
        end
    endtask

    initial begin : result_stall_gen
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_out_stall = 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge i_clk);
                i_out_stall   = 1'b0;
                long_hold_req = 1'b0;
            end else if (output_bursts && $urandom_range(0, 5) == 0) begin
                i_out_stall = 1'b1;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: result with nothing expected: class %0d flag %0b",
                         $time, o_class_code, o_useful_flag);
            end else begin
                want = expected_results.pop_front();
                if (o_class_code !== want.class_code) begin
                    error_count++;
                    $display("%0t: class_code expected %0d (%s) actual %0d",
                             $time, want.class_code, want.class_code.name(), o_class_code);
                end
                if (o_useful_flag !== want.useful_flag) begin
                    error_count++;
                    $display("%0t: useful_flag expected %0b actual %0b",
                             $time, want.useful_flag, o_useful_flag);
                end
            end
        end
    end

    initial begin : main_seq
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_tie();
        test_backpressure();
        test_random();
        wait_idle();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #3000000;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== prefetch_usefulness_classifier.f =====
+incdir+sv
sv/pur_pkg.sv
sv/pur_ram.sv
sv/pur_update.sv
sv/pur_classify.sv
sv/prefetch_usefulness_classifier.sv
dv/tb_top.sv
